// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the observer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check clocked on the rising edge, held off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition that must never be true at a rising edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/lrbo_pkg.sv
// Types, angle constants and CORDIC tables of the range and bearing observer.
package lrbo_pkg;

    // Datapath widths inside the CORDIC chain.
    localparam int W  = 44;
    localparam int ZW = 35;

    // Angles in signed Q30 radians.
    localparam longint ANG_HP = 64'sd1686629713;
    localparam longint ANG_QP = 64'sd843314857;
    localparam longint ANG_PI = 64'sd3373259426;

    // Rotation and vectoring vectors of one CORDIC cell.
    typedef struct packed {
        logic signed [W-1:0]  xr;
        logic signed [W-1:0]  yr;
        logic signed [ZW-1:0] zr;
        logic signed [W-1:0]  xv;
        logic signed [W-1:0]  yv;
        logic signed [ZW-1:0] zv;
    } t_cdat;

    // Side data that travels with each word.
    typedef struct packed {
        logic                 vld;
        logic [15:0]          id;
        logic                 last;
        logic                 ok;
        logic signed [ZW-1:0] h30;
    } t_tag;

    // One result word.
    typedef struct packed {
        logic               visible;
        logic [15:0]        seen_id;
        logic [30:0]        range_out;
        logic signed [15:0] bearing_out;
        logic               last_out;
    } t_res;

    // atan(2^-i) in Q30, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] a;
        begin
            unique case (i)
                0:  a = ZW'(64'sd843314857);
                1:  a = ZW'(64'sd497837829);
                2:  a = ZW'(64'sd263043837);
                3:  a = ZW'(64'sd133525159);
                4:  a = ZW'(64'sd67021687);
                5:  a = ZW'(64'sd33543516);
                6:  a = ZW'(64'sd16775851);
                7:  a = ZW'(64'sd8388437);
                8:  a = ZW'(64'sd4194283);
                9:  a = ZW'(64'sd2097149);
                10: a = ZW'(64'sd1048576);
                11: a = ZW'(64'sd524288);
                12: a = ZW'(64'sd262144);
                13: a = ZW'(64'sd131072);
                14: a = ZW'(64'sd65536);
                15: a = ZW'(64'sd32768);
                16: a = ZW'(64'sd16384);
                17: a = ZW'(64'sd8192);
                18: a = ZW'(64'sd4096);
                19: a = ZW'(64'sd2048);
                20: a = ZW'(64'sd1024);
                21: a = ZW'(64'sd512);
                22: a = ZW'(64'sd256);
                23: a = ZW'(64'sd128);
                default: a = '0;
            endcase
            return a;
        end
    endfunction

    // Inverse CORDIC gain in Q31 for n stages, evaluated at elaboration.
    function automatic logic [30:0] gain_inv(input int n);
        logic [63:0] k2;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        begin
            k2 = 64'd1 << 62;
            for (int i = 0; i < n; i++) begin
                d = (64'd1 << (2 * i)) + 64'd1;
                q = '0;
                rem = '0;
                for (int b = 63; b >= 0; b--) begin
                    rem = {rem[62:0], k2[b]};
                    if (rem >= d) begin
                        rem = rem - d;
                        q[b] = 1'b1;
                    end
                end
                k2 = k2 - q;
            end
            v = k2;
            res = '0;
            bt = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (v >= res + bt) begin
                    v = v - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            return res[30:0];
        end
    endfunction

endpackage

// File: rtl/lrbo_front.sv
// Front stages: differences, range tests and CORDIC start vectors.
module lrbo_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [31:0]    i_pose_x,
    input  logic signed [31:0]    i_pose_y,
    input  logic signed [15:0]    i_heading,
    input  logic signed [31:0]    i_landmark_x,
    input  logic signed [31:0]    i_landmark_y,
    input  logic [15:0]           i_landmark_id,
    input  logic                  i_last_landmark,
    input  logic [30:0]           i_max_range,
    output lrbo_pkg::t_cdat       o_dat,
    output lrbo_pkg::t_tag        o_tag
);
    import lrbo_pkg::*;

    // Stage one: differences and heading reduction.
    logic signed [32:0]    n_dx, n_dy;
    logic signed [ZW-1:0]  n_h30;
    logic signed [35:0]    n_t;
    logic signed [3:0]     n_k;
    logic signed [ZW-1:0]  n_z0;
    logic [3:0]            n_cnt;

    logic signed [31:0]    r_dx, r_dy;
    logic                  r_ovf;
    logic [1:0]            r_m;
    logic signed [ZW-1:0]  r_z0, r_h30;
    logic [15:0]           r_id1;
    logic                  r_last1, r_v1;

    always_comb begin
        n_dx  = 33'(i_landmark_x) - 33'(i_pose_x);
        n_dy  = 33'(i_landmark_y) - 33'(i_pose_y);
        n_h30 = {{(ZW-34){i_heading[15]}}, i_heading, 18'b0};
        n_t   = 36'(n_h30) + 36'(ANG_QP);
        n_cnt = '0;
        for (int j = -5; j <= 5; j++) begin
            if (longint'(n_t) >= longint'(j) * ANG_HP) n_cnt = n_cnt + 4'd1;
        end
        n_k  = $signed(n_cnt) - 4'sd6;
        n_z0 = ZW'(longint'(n_k) * ANG_HP - longint'(n_h30));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_dx    <= n_dx[31:0];
            r_dy    <= n_dy[31:0];
            r_ovf   <= (n_dx[32] != n_dx[31]) || (n_dy[32] != n_dy[31]);
            r_m     <= n_k[1:0];
            r_z0    <= n_z0;
            r_h30   <= n_h30;
            r_id1   <= i_landmark_id;
            r_last1 <= i_last_landmark;
        end
    end

    // Stage two: square of |dx|, quarter turns and half-turn fold.
    logic [31:0]          n_ax, n_ay;
    logic signed [W-1:0]  n_gx, n_gy;
    t_cdat                n_c;

    always_comb begin
        n_ax = r_dx[31] ? 32'(-33'(r_dx)) : r_dx;
        n_ay = r_dy[31] ? 32'(-33'(r_dy)) : r_dy;
        n_gx = {{(W-40){r_dx[31]}}, r_dx, 8'b0};
        n_gy = {{(W-40){r_dy[31]}}, r_dy, 8'b0};
        unique case (r_m)
            2'd0: begin n_c.xr = n_gx;  n_c.yr = n_gy;  end
            2'd1: begin n_c.xr = n_gy;  n_c.yr = -n_gx; end
            2'd2: begin n_c.xr = -n_gx; n_c.yr = -n_gy; end
            default: begin n_c.xr = -n_gy; n_c.yr = n_gx; end
        endcase
        n_c.zr = r_z0;
        if (r_dx[31]) begin
            n_c.xv = -n_gx;
            n_c.yv = -n_gy;
            n_c.zv = r_dy[31] ? ZW'(-ANG_PI) : ZW'(ANG_PI);
        end else begin
            n_c.xv = n_gx;
            n_c.yv = n_gy;
            n_c.zv = '0;
        end
    end

    logic [63:0]           r_sqx2, r_sqx3, r_sqy3;
    logic [31:0]           r_ax2, r_ay2, r_ax3, r_ay3;
    t_cdat                 r_c2, r_c3, r_c4;
    t_tag                  r_t2, r_t3, r_t4;
    logic                  r_ovf2, r_ovf3;
    logic [63:0]           r_r2;

    // Squared range limit, registered from the range register.
    always_ff @(posedge i_clk) begin
        r_r2 <= 64'(i_max_range) * 64'(i_max_range);
    end

    // Stages two to four: squares, then the range compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2.vld <= 1'b0;
            r_t3.vld <= 1'b0;
            r_t4.vld <= 1'b0;
        end else if (i_en) begin
            r_t2.vld <= r_v1;
            r_t3.vld <= r_t2.vld;
            r_t4.vld <= r_t3.vld;
        end
        if (i_en) begin
            r_sqx2     <= 64'(n_ax) * 64'(n_ax);
            r_ax2      <= n_ax;
            r_ay2      <= n_ay;
            r_ovf2     <= r_ovf;
            r_c2       <= n_c;
            r_t2.id    <= r_id1;
            r_t2.last  <= r_last1;
            r_t2.ok    <= 1'b0;
            r_t2.h30   <= r_h30;

            r_sqx3     <= r_sqx2;
            r_sqy3     <= 64'(r_ay2) * 64'(r_ay2);
            r_ax3      <= r_ax2;
            r_ay3      <= r_ay2;
            r_ovf3     <= r_ovf2;
            r_c3       <= r_c2;
            r_t3.id    <= r_t2.id;
            r_t3.last  <= r_t2.last;
            r_t3.ok    <= 1'b0;
            r_t3.h30   <= r_t2.h30;

            r_c4       <= r_c3;
            r_t4.id    <= r_t3.id;
            r_t4.last  <= r_t3.last;
            r_t4.h30   <= r_t3.h30;
            r_t4.ok    <= !r_ovf3 && (r_ax3 < 32'(i_max_range))
                          && (r_ay3 < 32'(i_max_range))
                          && ((r_sqx3 + r_sqy3) < r_r2);
        end
    end

    assign o_dat = r_c4;
    assign o_tag = r_t4;

endmodule

// File: rtl/lrbo_cell.sv
// One CORDIC cell: a rotation step and a vectoring step side by side.
module lrbo_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  lrbo_pkg::t_cdat  i_dat,
    input  lrbo_pkg::t_tag   i_tag,
    output lrbo_pkg::t_cdat  o_dat,
    output lrbo_pkg::t_tag   o_tag
);
    import lrbo_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_q30(IDX);

    t_cdat n_dat, r_dat;
    t_tag  r_tag;

    // Rotation drives z to zero; vectoring drives y to zero.
    always_comb begin
        if (i_dat.zr >= 0) begin
            n_dat.xr = i_dat.xr - (i_dat.yr >>> IDX);
            n_dat.yr = i_dat.yr + (i_dat.xr >>> IDX);
            n_dat.zr = i_dat.zr - ATAN;
        end else begin
            n_dat.xr = i_dat.xr + (i_dat.yr >>> IDX);
            n_dat.yr = i_dat.yr - (i_dat.xr >>> IDX);
            n_dat.zr = i_dat.zr + ATAN;
        end
        if (i_dat.yv > 0) begin
            n_dat.xv = i_dat.xv + (i_dat.yv >>> IDX);
            n_dat.yv = i_dat.yv - (i_dat.xv >>> IDX);
            n_dat.zv = i_dat.zv + ATAN;
        end else begin
            n_dat.xv = i_dat.xv - (i_dat.yv >>> IDX);
            n_dat.yv = i_dat.yv + (i_dat.xv >>> IDX);
            n_dat.zv = i_dat.zv - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_tag.vld <= i_tag.vld;
        end
        if (i_en) begin
            r_dat      <= n_dat;
            r_tag.id   <= i_tag.id;
            r_tag.last <= i_tag.last;
            r_tag.ok   <= i_tag.ok;
            r_tag.h30  <= i_tag.h30;
        end
    end

    assign o_dat = r_dat;
    assign o_tag = r_tag;

endmodule

// File: rtl/lrbo_back.sv
// Back end: forward test, gain correction of the range and bearing rounding.
module lrbo_back #(
    parameter logic [30:0] KINV = 31'd1304065748
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  lrbo_pkg::t_cdat  i_dat,
    input  lrbo_pkg::t_tag   i_tag,
    output logic             o_vld,
    output lrbo_pkg::t_res   o_res
);
    import lrbo_pkg::*;

    logic [35:0]          n_a;
    logic signed [35:0]   n_b;
    logic signed [17:0]   n_bs;
    logic signed [15:0]   n_bear;

    // Magnitude without guard bits, and the rounded, saturated bearing.
    always_comb begin
        n_a  = i_dat.xv[W-1] ? '0 : 36'(i_dat.xv[W-1:8]);
        n_b  = 36'(i_dat.zv) - 36'(i_tag.h30) + 36'sd131072;
        n_bs = n_b[35:18];
        if (n_bs > 18'sd32767) begin
            n_bear = 16'sd32767;
        end else if (n_bs < -18'sd32768) begin
            n_bear = -16'sd32768;
        end else begin
            n_bear = n_bs[15:0];
        end
    end

    logic [48:0]         r_pl, r_ph;
    logic signed [15:0]  r_bear;
    logic                r_vis, r_last, r_v;
    logic [15:0]         r_id;

    // Range product split into two partial products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_tag.vld;
        end
        if (i_en) begin
            r_pl   <= 49'(n_a[17:0]) * 49'(KINV);
            r_ph   <= 49'(n_a[35:18]) * 49'(KINV);
            r_bear <= n_bear;
            r_vis  <= i_tag.ok && (i_dat.xr > 0);
            r_id   <= i_tag.id;
            r_last <= i_tag.last;
        end
    end

    logic [67:0] n_sum;
    logic [30:0] n_rng;

    // Sum, round and saturate the range.
    always_comb begin
        n_sum = (68'(r_ph) << 18) + 68'(r_pl) + (68'd1 << 30);
        n_rng = (|n_sum[67:62]) ? 31'h7FFF_FFFF : n_sum[61:31];
        o_res.visible     = r_vis;
        o_res.seen_id     = r_id;
        o_res.range_out   = r_vis ? n_rng : '0;
        o_res.bearing_out = r_vis ? r_bear : '0;
        o_res.last_out    = r_last;
    end

    assign o_vld = r_v;

endmodule

// File: rtl/landmark_range_bearing_observer_unit.sv
// Top level of the landmark range and bearing observer.
// One landmark word is taken per clock and one result word leaves per clock, in order,
// while no stall holds the pipe. Words pass four front stages, the CORDIC cells,
// one back stage and the output register. A word is accepted when i_valid is high and
// o_stall low; results leave when o_valid is high and i_stall low, through an output
// register and a skid stage.
// max_range may be written at any time the block is idle; o_cfg_ready is always high.
`include "assert_macros.svh"
module landmark_range_bearing_observer_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [15:0] i_heading,
    input  logic signed [31:0] i_landmark_x,
    input  logic signed [31:0] i_landmark_y,
    input  logic [15:0]        i_landmark_id,
    input  logic               i_last_landmark,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_visible,
    output logic [15:0]        o_seen_id,
    output logic [30:0]        o_range_out,
    output logic signed [15:0] o_bearing_out,
    output logic               o_last_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [30:0]        i_cfg_data
);
    import lrbo_pkg::*;

    localparam logic [30:0] KINV = gain_inv(CORDIC_STAGES);

    logic [30:0] r_max_range;
    logic        en;

    // Range register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= 31'd1966080;
        end else if (i_cfg_valid) begin
            r_max_range <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    t_cdat c_dat [0:CORDIC_STAGES];
    t_tag  c_tag [0:CORDIC_STAGES];

    lrbo_front u_front (
        .i_clk, .i_rst_n, .i_en(en), .i_valid,
        .i_pose_x, .i_pose_y, .i_heading, .i_landmark_x, .i_landmark_y,
        .i_landmark_id, .i_last_landmark, .i_max_range(r_max_range),
        .o_dat(c_dat[0]), .o_tag(c_tag[0])
    );

    // Chain of CORDIC cells, one iteration each.
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        lrbo_cell #(.IDX(g)) u_cell (
            .i_clk, .i_rst_n, .i_en(en),
            .i_dat(c_dat[g]), .i_tag(c_tag[g]),
            .o_dat(c_dat[g+1]), .o_tag(c_tag[g+1])
        );
    end

    logic bk_vld;
    t_res bk_res;

    lrbo_back #(.KINV(KINV)) u_back (
        .i_clk, .i_rst_n, .i_en(en),
        .i_dat(c_dat[CORDIC_STAGES]), .i_tag(c_tag[CORDIC_STAGES]),
        .o_vld(bk_vld), .o_res(bk_res)
    );

    // Output register with a skid stage; the pipe halts only while the skid is full.
    t_res r_out, r_skd;
    logic r_out_v, r_skd_v;

    assign en      = !r_skd_v;
    assign o_stall = r_skd_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (r_out_v && i_stall) begin
            if (en && bk_vld) begin
                r_skd_v <= 1'b1;
            end
        end else if (r_skd_v) begin
            r_out_v <= 1'b1;
            r_skd_v <= 1'b0;
        end else begin
            r_out_v <= bk_vld;
        end
        if (r_out_v && i_stall) begin
            if (en && bk_vld) r_skd <= bk_res;
        end else if (r_skd_v) begin
            r_out <= r_skd;
        end else begin
            r_out <= bk_res;
        end
    end

    assign o_valid       = r_out_v;
    assign o_visible     = r_out.visible;
    assign o_seen_id     = r_out.seen_id;
    assign o_range_out   = r_out.range_out;
    assign o_bearing_out = r_out.bearing_out;
    assign o_last_out    = r_out.last_out;

    // The skid holds a word only behind a waiting output word.
    `ASSERT_NEVER(a_skid_behind_out, i_clk, i_rst_n, r_skd_v && !r_out_v)
    // The skid fills only when the output was stalled.
    `ASSERT_CLK(a_skid_fill, i_clk, i_rst_n, $rose(r_skd_v) |-> $past(r_out_v && i_stall))
    // An invisible landmark carries zero range and bearing.
    `ASSERT_CLK(a_invis_zero, i_clk, i_rst_n,
        (r_out_v && !r_out.visible) |-> (r_out.range_out == 0 && r_out.bearing_out == 0))

endmodule

// File: test/lrbo_checker.sv
// Checker that predicts and compares the result words of the range and bearing observer.
module lrbo_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [15:0] i_heading,
    input  logic signed [31:0] i_landmark_x,
    input  logic signed [31:0] i_landmark_y,
    input  logic [15:0]        i_landmark_id,
    input  logic               i_last_landmark,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_visible,
    input  logic [15:0]        i_seen_id,
    input  logic [30:0]        i_range_out,
    input  logic signed [15:0] i_bearing_out,
    input  logic               i_last_out,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [30:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    import lrbo_pkg::*;

    localparam longint HALF_PI    = 64'sd1686629713;
    localparam longint QUARTER_PI = 64'sd843314857;
    localparam longint FULL_PI    = 64'sd3373259426;
    localparam int     NSTG       = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

    // Arctangent of 2^-i in Q30 radians.
    localparam longint ARCTAN [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    logic [30:0] range_limit;
    t_res        expected_obs[$];
    bit   [63:0] inv_gain;

    // Inverse CORDIC gain in Q31, from the squared inverse gain in Q62.
    function automatic bit [63:0] inverse_gain();
        bit [63:0] k2;
        bit [63:0] v;
        bit [63:0] root;
        bit [63:0] bt;
        k2 = 64'd1 << 62;
        for (int i = 0; i < NSTG; i++) begin
            k2 = k2 - k2 / ((64'd1 << (2 * i)) + 64'd1);
        end
        v = k2;
        root = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= root + bt) begin
                v = v - (root + bt);
                root = (root >> 1) + bt;
            end else begin
                root = root >> 1;
            end
            bt = bt >> 2;
        end
        return root;
    endfunction

    // Sign of the projection of (x, y) on the heading direction.
    function automatic bit ahead_of_vehicle(input longint x0, input longint y0,
                                            input longint h30);
        longint x, y, z, k, m, t, xs, ys;
        x = x0;
        y = y0;
        k = (h30 + QUARTER_PI + 6 * HALF_PI) / HALF_PI - 6;
        z = -(h30 - k * HALF_PI);
        m = (k + 8) % 4;
        // Exact quarter turns first, then the fine rotation.
        while (m > 0) begin
            t = x;
            x = y;
            y = -t;
            m = m - 1;
        end
        for (int i = 0; i < NSTG; i++) begin
            xs = y >>> i;
            ys = x >>> i;
            if (z >= 0) begin
                x = x - xs;
                y = y + ys;
                z = z - ARCTAN[i];
            end else begin
                x = x + xs;
                y = y - ys;
                z = z + ARCTAN[i];
            end
        end
        return x > 0;
    endfunction

    // Vectoring pass: returns the angle in Q30 and the scaled magnitude.
    function automatic longint vector_angle(input longint x0, input longint y0,
                                            output longint mag);
        longint x, y, z, xs, ys;
        x = x0;
        y = y0;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? FULL_PI : -FULL_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < NSTG; i++) begin
            xs = y >>> i;
            ys = x >>> i;
            if (y > 0) begin
                x = x + xs;
                y = y - ys;
                z = z + ARCTAN[i];
            end else begin
                x = x - xs;
                y = y + ys;
                z = z - ARCTAN[i];
            end
        end
        mag = x;
        return z;
    endfunction

    // Expected result word for one landmark word.
    function automatic t_res observe_landmark(input logic signed [31:0] px,
            input logic signed [31:0] py, input logic signed [15:0] hd,
            input logic signed [31:0] lx, input logic signed [31:0] ly,
            input logic [15:0] id, input logic last, input logic [30:0] rmax);
        t_res        r;
        longint      dx, dy, ax, ay, h30, ang, mag, bear;
        bit   [63:0] d2, r2, a, rng;
        bit          vis;
        dx = longint'(lx) - longint'(px);
        dy = longint'(ly) - longint'(py);
        h30 = longint'(hd) * 262144;
        vis = 1'b1;
        rng = 0;
        bear = 0;
        // A difference outside 32 bits counts as invisible.
        if (dx < -64'sd2147483648 || dx > 64'sd2147483647 ||
            dy < -64'sd2147483648 || dy > 64'sd2147483647) vis = 1'b0;
        if (vis) begin
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            d2 = 64'(ax * ax) + 64'(ay * ay);
            r2 = 64'(rmax) * 64'(rmax);
            if (!(ax < longint'(rmax) && ay < longint'(rmax) && d2 < r2)) vis = 1'b0;
        end
        if (vis && !ahead_of_vehicle(dx * 256, dy * 256, h30)) vis = 1'b0;
        if (vis) begin
            ang = vector_angle(dx * 256, dy * 256, mag);
            a = (mag < 0) ? 64'd0 : 64'(mag) / 64'd256;
            rng = (a * inv_gain + (64'd1 << 30)) >> 31;
            if (rng > 64'h7FFFFFFF) rng = 64'h7FFFFFFF;
            bear = (ang - h30 + 131072) >>> 18;
            if (bear > 32767) bear = 32767;
            if (bear < -32768) bear = -32768;
        end
        r.visible = vis;
        r.seen_id = id;
        r.range_out = rng[30:0];
        r.bearing_out = bear[15:0];
        r.last_out = last;
        return r;
    endfunction

    initial begin
        inv_gain = inverse_gain();
    end

    // Follow the register, queue expectations and compare each result word.
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            range_limit = 31'd1966080;
            o_errors = 0;
            o_pending = 0;
            expected_obs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) range_limit = i_cfg_data;
            if (i_valid && !i_stall_in) begin
                expected_obs.insert(expected_obs.size(),
                    observe_landmark(i_pose_x, i_pose_y, i_heading,
                        i_landmark_x, i_landmark_y, i_landmark_id, i_last_landmark,
                        range_limit));
            end
            if (i_out_valid && !i_out_stall) begin
                got.visible = i_visible;
                got.seen_id = i_seen_id;
                got.range_out = i_range_out;
                got.bearing_out = i_bearing_out;
                got.last_out = i_last_out;
                if (expected_obs.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= 10)
                        $display("unexpected result word: vis=%0b id=%0d range=%0d bear=%0d",
                                 got.visible, got.seen_id, got.range_out, got.bearing_out);
                end else begin
                    want = expected_obs.pop_front();
                    if (got !== want) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= 10)
                            $display("mismatch: exp vis=%0b id=%0d range=%0d bear=%0d last=%0b, ",
                                     want.visible, want.seen_id, want.range_out,
                                     want.bearing_out, want.last_out,
                                     "got vis=%0b id=%0d range=%0d bear=%0d last=%0b",
                                     got.visible, got.seen_id, got.range_out,
                                     got.bearing_out, got.last_out);
                    end
                end
            end
            o_pending = expected_obs.size();
        end
    end

endmodule

// File: test/tb_top.sv
// Stimulus and verdict for the landmark range and bearing observer.
module tb_top;

    localparam int STAGES = 16;
    localparam logic signed [31:0] M1 = 32'sd65536;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_pose_x;
    logic signed [31:0] i_pose_y;
    logic signed [15:0] i_heading;
    logic signed [31:0] i_landmark_x;
    logic signed [31:0] i_landmark_y;
    logic [15:0]        i_landmark_id;
    logic               i_last_landmark;
    logic               o_valid;
    logic               i_stall;
    logic               o_visible;
    logic [15:0]        o_seen_id;
    logic [30:0]        o_range_out;
    logic signed [15:0] o_bearing_out;
    logic               o_last_out;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [30:0]        i_cfg_data;
    int                 errors;
    int                 pending;
    int                 gap_pct;
    int                 stall_pct;
    logic               stall_seen;
    logic               cfg_ready_seen;
    logic [30:0]        cur_range;

    landmark_range_bearing_observer_unit #(.CORDIC_STAGES(STAGES)) dut (.*);

    lrbo_checker #(.CORDIC_STAGES(STAGES)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_pose_x(i_pose_x), .i_pose_y(i_pose_y), .i_heading(i_heading),
        .i_landmark_x(i_landmark_x), .i_landmark_y(i_landmark_y),
        .i_landmark_id(i_landmark_id), .i_last_landmark(i_last_landmark),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_visible(o_visible),
        .i_seen_id(o_seen_id), .i_range_out(o_range_out), .i_bearing_out(o_bearing_out),
        .i_last_out(o_last_out), .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data), .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Handshake levels sampled on the falling edge, ahead of the rising edge that uses them.
    always @(negedge i_clk) begin
        stall_seen = o_stall;
        cfg_ready_seen = o_cfg_ready;
    end

    // Receiver stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        #3000000;
        $display("tb_top failed");
        $finish;
    end

    // Send one landmark word after a random gap and wait until it is taken.
    task automatic send_landmark(input logic signed [31:0] px, input logic signed [31:0] py,
                                 input logic signed [15:0] hd, input logic signed [31:0] lx,
                                 input logic signed [31:0] ly, input logic [15:0] id,
                                 input logic last);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pose_x <= px;
        i_pose_y <= py;
        i_heading <= hd;
        i_landmark_x <= lx;
        i_landmark_y <= ly;
        i_landmark_id <= id;
        i_last_landmark <= last;
        do @(posedge i_clk); while (stall_seen);
    endtask

    // Let the pipe drain completely, with the input side idle.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (STAGES + 10) @(posedge i_clk);
    endtask

    // Write max_range while the block is idle.
    task automatic write_range(input logic [30:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready_seen);
        i_cfg_valid <= 1'b0;
        cur_range = value;
    endtask

    // Landmark near the pose, scaled to the current range, or a wild word.
    task automatic send_random();
        logic signed [31:0] px, py, lx, ly;
        longint             span, off;
        px = $urandom;
        py = $urandom;
        if ($urandom_range(99) < 85) begin
            span = longint'(cur_range) + longint'(cur_range) / 2 + 262144;
            if (span > 64'sd2147483647) span = 64'sd2147483647;
            off = longint'({$urandom} % (2 * span)) - span;
            lx = px + 32'(off);
            off = longint'({$urandom} % (2 * span)) - span;
            ly = py + 32'(off);
        end else begin
            lx = $urandom;
            ly = $urandom;
        end
        send_landmark(px, py, 16'($urandom), lx, ly, 16'($urandom_range(65535)),
                      1'($urandom_range(1)));
    endtask

    initial begin
        logic [30:0] settings [0:5];
        int          gaps [0:3];
        int          stalls [0:3];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pose_x = '0;
        i_pose_y = '0;
        i_heading = '0;
        i_landmark_x = '0;
        i_landmark_y = '0;
        i_landmark_id = '0;
        i_last_landmark = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        gap_pct = 0;
        stall_pct = 0;
        cur_range = 31'd1966080;
        settings = '{31'h7FFFFFFF, 31'd0, 31'd327680, 31'd1, 31'd1966080, 31'h00ABCDEF};
        gaps = '{0, 82, 0, 35};
        stalls = '{0, 0, 82, 35};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset range of 30 m.
        send_landmark(0, 0, 0, 10 * M1, 0, 16'h0000, 1'b0);
        send_landmark(0, 0, 0, -10 * M1, 0, 16'hFFFF, 1'b1);
        send_landmark(5 * M1, 5 * M1, 16'sd1000, 5 * M1, 5 * M1, 16'd2, 1'b0);
        send_landmark(32'sh80000000, 0, 0, 32'sh7FFFFFFF, 0, 16'd3, 1'b1);
        send_landmark(0, 32'sh7FFFFFFF, 0, 0, 32'sh80000000, 16'd4, 1'b0);
        send_landmark(0, 0, 16'sh7FFF, 10 * M1, 10 * M1, 16'd5, 1'b0);
        send_landmark(0, 0, 16'sh8000, -10 * M1, 3 * M1, 16'd6, 1'b0);
        send_landmark(0, 0, 0, 40 * M1, 0, 16'd7, 1'b0);
        send_landmark(0, 0, 0, 0, 10 * M1, 16'd8, 1'b0);
        send_landmark(0, 0, 16'sd6434, 0, 10 * M1, 16'd9, 1'b0);
        send_landmark(0, 0, 0, 25 * M1, 25 * M1, 16'd10, 1'b0);
        send_landmark(0, 0, 0, 30 * M1, 0, 16'd11, 1'b0);
        send_landmark(0, 0, 0, 30 * M1 - 1, 0, 16'd12, 1'b1);
        send_landmark(-7 * M1, 3 * M1, -16'sd12868, -7 * M1 - 5, 3 * M1 - 9, 16'd13, 1'b0);
        send_landmark(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sd3000,
                      32'sh7FFFFFFF - M1, 32'sh7FFFFFFF - M1, 16'd14, 1'b0);
        send_landmark(0, 0, 0, -3 * M1, -20 * M1, 16'd15, 1'b1);

        // Random words over several register settings and idling patterns.
        for (int phase = 0; phase < 8; phase++) begin
            write_range(settings[phase % 6]);
            gap_pct = gaps[phase % 4];
            stall_pct = stalls[phase % 4];
            for (int n = 0; n < 112; n++) begin
                if (n == 60 && phase == 2) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                send_random();
            end
        end

        stall_pct = 20;
        drain();
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
